/* hdl/salru_pkg.sv */
// shared types and codes for the set-associative lru cache with victim buffer
package salru_pkg;

  // width of the outcome code and of the running miss count
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned MISS_W    = 32;
  localparam int unsigned ADDR_IN_W = 32;

  typedef logic [OUTCOME_W-1:0] outcome_t;

  localparam outcome_t OUT_HIT    = 2'd0;
  localparam outcome_t OUT_VICTIM = 2'd1;
  localparam outcome_t OUT_MISS   = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } ctrl_state_t;

endpackage

/* hdl/salru_ram.sv */
// generic single-write, single-read memory with registered read data
module salru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/set_assoc_lru_cache_with_victim_buffer.sv */
// top level: set-associative lru cache model with a small fully associative victim buffer
//
//  channel  | ports                                          | direction
//  ---------+------------------------------------------------+----------
//  input    | in_valid, in_stall, in_address                 | address in
//  result   | out_valid, out_stall, out_outcome,             | result out
//           | out_set_index, out_miss_total                  |
//
// in each transaction the set row is read from the row memory in the accept cycle, then
// tags are compared, the row is written back and the result registered
// a result waiting in the output register does not block the next address; that address
// is looked up and completes as soon as the output register frees
// after reset a clearing pass writes every set row once, with in_stall high
// victim buffer in flip-flops; valid bits, ages and miss counter cleared by reset
module set_assoc_lru_cache_with_victim_buffer
  import salru_pkg::*;
#(
  parameter int unsigned ADDR_BITS      = 32,
  parameter int unsigned LINE_BYTES     = 64,
  parameter int unsigned WAYS           = 2,
  parameter int unsigned SET_COUNT      = 4,
  parameter int unsigned VICTIM_ENTRIES = 2
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_stall,
  input  logic [ADDR_IN_W-1:0]                             in_address,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic [OUTCOME_W-1:0]                             out_outcome,
  output logic [((SET_COUNT > 1) ? $clog2(SET_COUNT) : 1)-1:0] out_set_index,
  output logic [MISS_W-1:0]                                out_miss_total
);

  // address split; line size and set count are powers of two
  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned LOG_SETS = $clog2(SET_COUNT);
  localparam int unsigned SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int unsigned KEY_W    = ADDR_BITS - OFF_W;
  localparam int unsigned TAG_W    = (KEY_W > LOG_SETS) ? (KEY_W - LOG_SETS) : 1;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W    = $clog2(WAYS + 1);
  localparam int unsigned VI_W     = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int unsigned ROW_W    = WAYS * (1 + RANK_W + TAG_W);
  localparam int unsigned KT_W     = KEY_W + TAG_W + SET_W;

  localparam logic [KEY_W-1:0]  SET_MASK = KEY_W'(SET_COUNT - 1);
  localparam logic [SET_W-1:0]  LAST_SET = SET_W'(SET_COUNT - 1);
  localparam logic [VI_W-1:0]   OLDEST   = VI_W'(VICTIM_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(WAYS);

  // one way of a set row: valid, recency rank (0 = least recent) and tag
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_t;

  // control
  ctrl_state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_idx_r, clr_idx_nxt;
  logic             accept;
  logic             go;

  // input address split
  logic [ADDR_BITS+ADDR_IN_W-1:0] addr_wide;
  logic [ADDR_BITS-1:0]           addr_cut;
  logic [KEY_W-1:0]               key_in;
  logic [SET_W-1:0]               set_in;

  // item under lookup
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;

  // row memory
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  way_t [WAYS-1:0]      row_rd;
  way_t [WAYS-1:0]      row_upd;
  way_t [WAYS-1:0]      row_rst;

  // set lookup
  logic [WAYS-1:0]   hit_w;
  logic              hit_any;
  logic [RANK_W-1:0] hit_way;
  logic [RANK_W-1:0] hit_rank;
  logic [CNT_W-1:0]  fill_n;
  logic              full;
  logic              inv_found;
  logic [RANK_W-1:0] inv_way;
  logic              lru_found;
  logic [RANK_W-1:0] lru_way;
  logic [TAG_W-1:0]  lru_tag;
  logic [RANK_W-1:0] tgt_way;
  logic [RANK_W-1:0] thr_rank;
  logic              touch;

  // victim buffer
  logic [KEY_W-1:0] vk_r   [VICTIM_ENTRIES];
  logic [KEY_W-1:0] vk_nxt [VICTIM_ENTRIES];
  logic [VICTIM_ENTRIES-1:0] vv_r, vv_nxt;
  logic [VI_W-1:0]  va_r   [VICTIM_ENTRIES];
  logic [VI_W-1:0]  va_nxt [VICTIM_ENTRIES];
  logic [VICTIM_ENTRIES-1:0] vhit_e;
  logic             vhit_any;
  logic [VI_W-1:0]  vhit_idx;
  logic [VI_W-1:0]  vhit_age;
  logic             vfree_found;
  logic [VI_W-1:0]  vfree_idx;
  logic             vold_found;
  logic [VI_W-1:0]  vold_idx;
  logic [VI_W-1:0]  push_slot;
  logic [KEY_W-1:0] push_key;
  logic             evict;
  logic [VICTIM_ENTRIES-1:0] young;

  // miss counter and result register
  logic [MISS_W-1:0]    miss_cnt_r, miss_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0] out_outcome_r, out_outcome_nxt;
  logic [SET_W-1:0]     out_set_r, out_set_nxt;
  logic [MISS_W-1:0]    out_miss_r, out_miss_nxt;

  // address truncated to ADDR_BITS, then split into block key and set
  assign addr_wide = {{ADDR_BITS{1'b0}}, in_address};
  assign addr_cut  = addr_wide[ADDR_BITS-1:0];
  assign key_in    = KEY_W'(addr_cut >> OFF_W);
  assign set_in    = SET_W'(key_in & SET_MASK);

  assign cur_set = SET_W'(key_r & SET_MASK);
  assign cur_tag = TAG_W'(key_r >> LOG_SETS);

  assign accept = in_valid && !in_stall;
  assign go     = (state_r == ST_LOOK) && (!out_valid_r || !out_stall);

  // control state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        // one row per cycle until the last set is written
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SET) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // key of the accepted address
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end
  assign key_nxt = accept ? key_in : key_r;

  // row memory: read at accept, written back on completion or by the clearing pass
  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // reset row: all ways invalid, ranks in way order
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      row_rst[w].valid = 1'b0;
      row_rst[w].rank  = RANK_W'(w);
      row_rst[w].tag   = '0;
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || go;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_idx_r : cur_set;
  assign ram_wdata = (state_r == ST_CLEAR) ? row_rst : row_upd;

  // set search: tag hit, fill level, first free way and lru way
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    hit_rank  = '0;
    fill_n    = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_found = 1'b0;
    lru_way   = '0;
    lru_tag   = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_w[w] = row_rd[w].valid && (row_rd[w].tag == cur_tag);
      if (hit_w[w] && !hit_any) begin
        hit_any  = 1'b1;
        hit_way  = RANK_W'(w);
        hit_rank = row_rd[w].rank;
      end
      if (row_rd[w].valid) begin
        fill_n = fill_n + 1'b1;
      end
      if (!row_rd[w].valid && !inv_found) begin
        inv_found = 1'b1;
        inv_way   = RANK_W'(w);
      end
      if ((row_rd[w].rank == '0) && !lru_found) begin
        lru_found = 1'b1;
        lru_way   = RANK_W'(w);
        lru_tag   = row_rd[w].tag;
      end
    end
  end

  assign full = (fill_n == FULL_CNT);

  // hit: promote the hit way; miss or victim hit: fill a free way, or replace the lru way
  always_comb begin
    touch    = hit_any || full;
    tgt_way  = hit_any ? hit_way : (full ? lru_way : inv_way);
    thr_rank = hit_any ? hit_rank : '0;
    for (int w = 0; w < WAYS; w++) begin
      row_upd[w] = row_rd[w];
      if (touch && row_rd[w].valid && (row_rd[w].rank > thr_rank)) begin
        row_upd[w].rank = row_rd[w].rank - 1'b1;
      end
      if (RANK_W'(w) == tgt_way) begin
        row_upd[w].rank = touch ? RANK_W'(fill_n - 1'b1) : RANK_W'(fill_n);
        if (!hit_any) begin
          row_upd[w].valid = 1'b1;
          row_upd[w].tag   = cur_tag;
        end
      end
    end
  end

  // victim buffer search, free slot and oldest slot
  always_comb begin
    vhit_any    = 1'b0;
    vhit_idx    = '0;
    vhit_age    = '0;
    vfree_found = 1'b0;
    vfree_idx   = '0;
    vold_found  = 1'b0;
    vold_idx    = '0;
    for (int e = 0; e < VICTIM_ENTRIES; e++) begin
      vhit_e[e] = vv_r[e] && (vk_r[e] == key_r);
      young[e]  = vv_r[e] && (va_r[e] == '0);
      if (vhit_e[e] && !vhit_any) begin
        vhit_any = 1'b1;
        vhit_idx = VI_W'(e);
        vhit_age = va_r[e];
      end
      if (!vv_r[e] && !vfree_found) begin
        vfree_found = 1'b1;
        vfree_idx   = VI_W'(e);
      end
      if ((va_r[e] == OLDEST) && !vold_found) begin
        vold_found = 1'b1;
        vold_idx   = VI_W'(e);
      end
    end
  end

  // a miss on a full set pushes the lru block, keyed by its tag and this set
  assign evict     = !hit_any && !vhit_any && full;
  assign push_slot = vfree_found ? vfree_idx : vold_idx;
  assign push_key  = KEY_W'((KT_W'(lru_tag) << LOG_SETS) | KT_W'(cur_set));

  always_comb begin
    vv_nxt = vv_r;
    for (int e = 0; e < VICTIM_ENTRIES; e++) begin
      vk_nxt[e] = vk_r[e];
      va_nxt[e] = va_r[e];
      if (go && !hit_any && vhit_any) begin
        // remove the hit entry, the ages of older entries close the gap
        if (VI_W'(e) == vhit_idx) begin
          vv_nxt[e] = 1'b0;
        end else if (vv_r[e] && (va_r[e] > vhit_age)) begin
          va_nxt[e] = va_r[e] - 1'b1;
        end
      end else if (go && evict) begin
        // newest entry at age zero, the rest age by one
        if (VI_W'(e) == push_slot) begin
          vk_nxt[e] = push_key;
          vv_nxt[e] = 1'b1;
          va_nxt[e] = '0;
        end else if (vv_r[e]) begin
          va_nxt[e] = va_r[e] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r <= '0;
      for (int e = 0; e < VICTIM_ENTRIES; e++) begin
        va_r[e] <= '0;
      end
    end else begin
      vv_r <= vv_nxt;
      for (int e = 0; e < VICTIM_ENTRIES; e++) begin
        va_r[e] <= va_nxt[e];
      end
    end
  end

  // keys are only looked at behind their valid bit
  always_ff @(posedge clk) begin
    for (int e = 0; e < VICTIM_ENTRIES; e++) begin
      vk_r[e] <= vk_nxt[e];
    end
  end

  // miss counter and result register
  always_comb begin
    miss_cnt_nxt    = miss_cnt_r;
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_set_nxt     = out_set_r;
    out_miss_nxt    = out_miss_r;
    if (go) begin
      out_valid_nxt = 1'b1;
      out_set_nxt   = cur_set;
      priority if (hit_any) begin
        out_outcome_nxt = OUT_HIT;
        out_miss_nxt    = miss_cnt_r;
      end else if (vhit_any) begin
        out_outcome_nxt = OUT_VICTIM;
        out_miss_nxt    = miss_cnt_r;
      end else begin
        out_outcome_nxt = OUT_MISS;
        miss_cnt_nxt    = miss_cnt_r + 1'b1;
        out_miss_nxt    = miss_cnt_r + 1'b1;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_outcome_r <= out_outcome_nxt;
    out_set_r     <= out_set_nxt;
    out_miss_r    <= out_miss_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = out_outcome_r;
  assign out_set_index  = out_set_r;
  assign out_miss_total = out_miss_r;

  // a new result only ever comes out of a completed lookup
  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result appeared without a lookup");

  // the miss count moves only together with a miss result
  a_miss_count_moves_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (miss_cnt_r != $past(miss_cnt_r)))
      |-> (out_valid_r && (out_outcome_r == OUT_MISS) && (out_miss_r == miss_cnt_r)))
    else $error("miss count changed without a miss result");

  // a block lives in at most one place: one way of its set or the victim buffer
  a_block_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> ($onehot0(hit_w) && $onehot0(vhit_e) && !(hit_any && vhit_any)))
    else $error("block found in more than one place");

  // at most one valid victim entry is the newest
  a_single_newest_victim: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(young))
    else $error("victim ages not distinct");

endmodule
